### hdl/dfh_pkg.sv
package dfh_pkg;

    localparam int KEY_W = 30;
    localparam int CFG_W = 4;
    localparam logic [CFG_W-1:0] FOLD_RESET = 4'd3;
    localparam logic [3:0] DEC_BASE = 4'd10;
    localparam logic [3:0] DABBLE_MIN = 4'd5;
    localparam logic [3:0] DABBLE_ADJ = 4'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_NSET,
        S_NORM,
        S_ADD,
        S_OUT,
        S_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic conv;
        logic nset;
        logic nshift;
        logic add_init;
        logic add_step;
        logic out_init;
        logic out_step;
    } cmd_t;

    typedef struct packed {
        logic conv_last;
        logic norm_stop;
        logic fits;
        logic add_last;
        logic out_last;
    } status_t;

endpackage

### hdl/dfh_ctrl.sv
module dfh_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  dfh_pkg::status_t   sts,
    output dfh_pkg::cmd_t      cmd,
    output logic               busy,
    output logic               done
);

    dfh_pkg::state_t state_reg;
    dfh_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dfh_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        done       = 1'b0;
        case (state_reg)
            dfh_pkg::S_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = dfh_pkg::S_CONV;
                end
            end
            dfh_pkg::S_CONV:
            begin
                cmd.conv = 1'b1;
                if (sts.conv_last)
                begin
                    state_next = dfh_pkg::S_NSET;
                end
            end
            dfh_pkg::S_NSET:
            begin
                cmd.nset   = 1'b1;
                state_next = dfh_pkg::S_NORM;
            end
            dfh_pkg::S_NORM:
            begin
                if (!sts.norm_stop)
                begin
                    cmd.nshift = 1'b1;
                end
                else if (sts.fits)
                begin
                    cmd.out_init = 1'b1;
                    state_next   = dfh_pkg::S_OUT;
                end
                else
                begin
                    cmd.add_init = 1'b1;
                    state_next   = dfh_pkg::S_ADD;
                end
            end
            dfh_pkg::S_ADD:
            begin
                cmd.add_step = 1'b1;
                if (sts.add_last)
                begin
                    state_next = dfh_pkg::S_NSET;
                end
            end
            dfh_pkg::S_OUT:
            begin
                cmd.out_step = 1'b1;
                if (sts.out_last)
                begin
                    state_next = dfh_pkg::S_DONE;
                end
            end
            dfh_pkg::S_DONE:
            begin
                done       = 1'b1;
                state_next = dfh_pkg::S_IDLE;
            end
            default:
            begin
                state_next = dfh_pkg::S_IDLE;
            end
        endcase
    end

endmodule

### hdl/dfh_dp.sv
module dfh_dp #(
    parameter int MAX_DIGITS = 9
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  dfh_pkg::cmd_t               cmd,
    input  logic [dfh_pkg::KEY_W-1:0]   key,
    input  logic [dfh_pkg::CFG_W-1:0]   fold,
    output dfh_pkg::status_t            sts,
    output logic [dfh_pkg::KEY_W-1:0]   hash_index
);

    localparam int KW   = dfh_pkg::KEY_W;
    localparam int CTOP = (KW > MAX_DIGITS) ? KW : MAX_DIGITS;
    localparam int CNTW = $clog2(CTOP + 1);

    logic [KW-1:0]                  key_reg;
    logic [MAX_DIGITS-1:0][3:0]     dig_reg;
    logic [MAX_DIGITS-1:0][3:0]     upa_reg;
    logic [KW-1:0]                  acc_reg;
    logic [CNTW-1:0]                cnt_reg;
    logic                           carry_reg;
    logic [CNTW-1:0]                r_reg;
    logic [CNTW-1:0]                off_reg;
    logic [CNTW-1:0]                k_reg;

    logic [MAX_DIGITS-1:0][3:0]     adj;
    logic [4*MAX_DIGITS:0]          dab_w;
    logic [CNTW-1:0]                fold_ext;
    logic [CNTW-1:0]                lsel;
    logic [CNTW-1:0]                dcnt;
    logic [CNTW-1:0]                rsel;
    logic [CNTW-1:0]                offsel;
    logic [CNTW-1:0]                ksel;
    logic                           a_en;
    logic [3:0]                     a_dig;
    logic [3:0]                     b_dig;
    logic [4:0]                     sum5;
    logic                           ge;
    logic [3:0]                     res_dig;

    // add 3 to every digit of five or more before each doubling
    always_comb
    begin
        for (int i = 0; i < MAX_DIGITS; i++)
        begin
            adj[i] = (dig_reg[i] >= dfh_pkg::DABBLE_MIN) ? dig_reg[i] + dfh_pkg::DABBLE_ADJ
                                                          : dig_reg[i];
        end
    end
    assign dab_w = {adj, key_reg[KW-1]};

    always_comb
    begin
        fold_ext = CNTW'(fold);
        if (fold_ext == '0)
        begin
            lsel = CNTW'(1);
        end
        else if (fold_ext > CNTW'(MAX_DIGITS))
        begin
            lsel = CNTW'(MAX_DIGITS);
        end
        else
        begin
            lsel = fold_ext;
        end
        dcnt   = CNTW'(MAX_DIGITS) - cnt_reg;
        rsel   = dcnt - lsel;
        offsel = (lsel < rsel) ? rsel - lsel : '0;
        ksel   = (lsel < rsel) ? rsel : lsel;
    end

    // one decimal digit of the fold sum per cycle, lowest first
    always_comb
    begin
        a_en    = (cnt_reg >= off_reg) && (cnt_reg < off_reg + lsel);
        a_dig   = a_en ? upa_reg[MAX_DIGITS-1] : 4'd0;
        b_dig   = (cnt_reg < r_reg) ? dig_reg[0] : 4'd0;
        sum5    = {1'b0, a_dig} + {1'b0, b_dig} + {4'd0, carry_reg};
        ge      = sum5 >= {1'b0, dfh_pkg::DEC_BASE};
        res_dig = '0;
        if (cnt_reg < k_reg)
        begin
            res_dig = ge ? 4'(sum5 - {1'b0, dfh_pkg::DEC_BASE}) : sum5[3:0];
        end
    end

    assign sts.conv_last = cnt_reg == CNTW'(KW - 1);
    assign sts.norm_stop = (upa_reg[MAX_DIGITS-1] != 4'd0) || (cnt_reg == CNTW'(MAX_DIGITS));
    assign sts.fits      = dcnt <= lsel;
    assign sts.add_last  = cnt_reg == CNTW'(MAX_DIGITS - 1);
    assign sts.out_last  = cnt_reg == CNTW'(MAX_DIGITS - 1);
    assign hash_index    = acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            carry_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load || cmd.nset || cmd.add_init || cmd.out_init)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.conv || cmd.nshift || cmd.add_step || cmd.out_step)
            begin
                cnt_reg <= cnt_reg + CNTW'(1);
            end
            if (cmd.add_init)
            begin
                carry_reg <= 1'b0;
            end
            else if (cmd.add_step)
            begin
                carry_reg <= ge;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            key_reg <= key;
            dig_reg <= '0;
        end
        else if (cmd.conv)
        begin
            key_reg <= {key_reg[KW-2:0], 1'b0};
            dig_reg <= dab_w[4*MAX_DIGITS-1:0];
        end
        else if (cmd.add_step)
        begin
            dig_reg <= {res_dig, dig_reg[MAX_DIGITS-1:1]};
        end
        else if (cmd.out_step)
        begin
            dig_reg <= {dig_reg[MAX_DIGITS-2:0], 4'd0};
        end

        // normalize the copy so its top digit is the leading digit of the current value
        if (cmd.nset)
        begin
            upa_reg <= dig_reg;
        end
        else if (cmd.nshift || (cmd.add_step && a_en))
        begin
            upa_reg <= {upa_reg[MAX_DIGITS-2:0], 4'd0};
        end

        if (cmd.add_init)
        begin
            r_reg   <= rsel;
            off_reg <= offsel;
            k_reg   <= ksel;
        end

        if (cmd.out_init)
        begin
            acc_reg <= '0;
        end
        else if (cmd.out_step)
        begin
            acc_reg <= (acc_reg << 3) + (acc_reg << 1) + KW'(dig_reg[MAX_DIGITS-1]);
        end
    end

endmodule

### hdl/decimal_fold_hash.sv
// Sequence: load, binary-to-decimal conversion of the 30-bit key, then per fold pass a
// normalize phase and a digit-serial decimal add (no add on the last pass), then
// conversion back to binary and the done strobe.
// One key at a time: busy stays high through the done strobe, and a new start is
// taken only in the idle state.
// Reset: asynchronous, active low; clears the controller and sets the fold register to 3.
// done is high for one cycle, hash_index until the next key; the receiver cannot stall.
module decimal_fold_hash #(
    parameter int MAX_DIGITS = 9
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [dfh_pkg::KEY_W-1:0]   key,
    output logic                        done,
    output logic [dfh_pkg::KEY_W-1:0]   hash_index,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [dfh_pkg::CFG_W-1:0]   cfg_data
);

    dfh_pkg::cmd_t              cmd;
    dfh_pkg::status_t           sts;
    logic [dfh_pkg::CFG_W-1:0]  fold_reg;

    assign cfg_ready = !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fold_reg <= dfh_pkg::FOLD_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            fold_reg <= cfg_data;
        end
    end

    dfh_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    dfh_dp #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .key        (key),
        .fold       (fold_reg),
        .sts        (sts),
        .hash_index (hash_index)
    );

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("done held longer than one cycle");
    a_done_frees: assert property (@(posedge clk) disable iff (!rst_n) done |=> !busy)
        else $error("block still busy after done");
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !done))
        else $error("accepted key did not make the block busy");
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.conv, cmd.add_step, cmd.out_step}))
        else $error("conflicting digit register commands");

endmodule
